@@ rtl/sfa_pkg.sv @@
`default_nettype none

package sfa_pkg;

	// Decision taken for an accepted logit.
	typedef enum logic [1:0] {
		MODE_FIRST,
		MODE_NEWMAX,
		MODE_OTHER,
		MODE_IGNORE
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exp1;
		logic exp2;
		logic acc;
		logic scale;
		logic div_start;
		logic div_step;
		logic emit;
	} sfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t mode;
		logic  last;
		logic  div_last;
		logic  out_free;
	} sfa_sts_t;

	localparam int EXP_W       = 17;
	localparam int SUM_W       = 32;
	localparam int EXP_CUTOFF  = 3072;
	localparam int DIV_STEPS   = 17;
	localparam int DIV_CNT_W   = 5;
	localparam logic [EXP_W-1:0] ONE_Q16 = 17'h1_0000;

	// exp(-i) in Q1.16; beyond eleven the table itself gives zero.
	function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] i);
		logic [EXP_W-1:0] v;
		unique case (i)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd24109;
			4'd2:    v = 17'd8869;
			4'd3:    v = 17'd3263;
			4'd4:    v = 17'd1200;
			4'd5:    v = 17'd442;
			4'd6:    v = 17'd162;
			4'd7:    v = 17'd60;
			4'd8:    v = 17'd22;
			4'd9:    v = 17'd8;
			4'd10:   v = 17'd3;
			4'd11:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// exp(-h/16) in Q1.16.
	function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] h);
		logic [EXP_W-1:0] v;
		unique case (h)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd61565;
			4'd2:  v = 17'd57835;
			4'd3:  v = 17'd54331;
			4'd4:  v = 17'd51039;
			4'd5:  v = 17'd47947;
			4'd6:  v = 17'd45042;
			4'd7:  v = 17'd42313;
			4'd8:  v = 17'd39750;
			4'd9:  v = 17'd37341;
			4'd10: v = 17'd35079;
			4'd11: v = 17'd32954;
			4'd12: v = 17'd30957;
			4'd13: v = 17'd29081;
			4'd14: v = 17'd27319;
			4'd15: v = 17'd25664;
		endcase
		return v;
	endfunction

	// exp(-l/256) in Q1.16.
	function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] l);
		logic [EXP_W-1:0] v;
		unique case (l)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd65280;
			4'd2:  v = 17'd65026;
			4'd3:  v = 17'd64772;
			4'd4:  v = 17'd64520;
			4'd5:  v = 17'd64268;
			4'd6:  v = 17'd64018;
			4'd7:  v = 17'd63768;
			4'd8:  v = 17'd63520;
			4'd9:  v = 17'd63272;
			4'd10: v = 17'd63025;
			4'd11: v = 17'd62780;
			4'd12: v = 17'd62535;
			4'd13: v = 17'd62291;
			4'd14: v = 17'd62048;
			4'd15: v = 17'd61806;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sfa_dp.sv @@
`default_nettype none

module sfa_dp #(
	parameter int MAX_CLASSES = 1024,
	parameter int LOGIT_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire sfa_pkg::sfa_cmd_t            cmd,
	output sfa_pkg::sfa_sts_t                 sts,
	input  wire logic signed [LOGIT_BITS-1:0] logit,
	input  wire logic                         last,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [9:0]                        class_index,
	output logic [15:0]                       score
);

	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int PW = $clog2(MAX_CLASSES);
	localparam int DW = (LOGIT_BITS + 1 > 12) ? LOGIT_BITS + 1 : 12;
	localparam int EW = sfa_pkg::EXP_W;
	localparam int SW = sfa_pkg::SUM_W;
	localparam int PRW = SW + EW;
	localparam int NW = sfa_pkg::DIV_CNT_W;

	// Run state.
	logic signed [LOGIT_BITS-1:0] max_q;
	logic [PW-1:0]                pos_q;
	logic [CW-1:0]                count_q;
	logic [SW-1:0]                sum_q;
	sfa_pkg::mode_t               mode_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [NW-1:0]                div_cnt_q;

	// Working registers.
	logic [DW-1:0]  d_q;
	logic [EW-1:0]  v1_q;
	logic [EW-1:0]  e_q;
	logic [PRW-1:0] prod_q;
	logic [SW-1:0]  div_q;
	logic [SW-1:0]  rem_q;
	logic [EW-1:0]  quo_q;
	logic           small_q;
	logic [9:0]     class_index_q;
	logic [15:0]    score_q;

	logic signed [DW-1:0] xe;
	logic signed [DW-1:0] me;
	logic                 gt;
	logic                 first;
	logic                 full;
	logic [DW-1:0]        d_next;
	sfa_pkg::mode_t       mode_next;
	logic                 big;
	logic [2*EW-1:0]      p1;
	logic [2*EW-1:0]      r1;
	logic [2*EW-1:0]      p2;
	logic [2*EW-1:0]      r2;
	logic [SW:0]          add_sum;
	logic [SW-1:0]        sum_add;
	logic [PRW-1:0]       rnd;
	logic [SW+1:0]        sc_sum;
	logic [SW-1:0]        sum_scale;
	logic [SW:0]          trial;
	logic [SW:0]          trial_diff;
	logic                 ge;

	assign xe    = DW'(logit);
	assign me    = DW'(max_q);
	assign gt    = logit > max_q;
	assign first = count_q == '0;
	assign full  = count_q == CW'(MAX_CLASSES);

	assign d_next = gt ? DW'(xe - me) : DW'(me - xe);

	always_comb begin
		if (full) begin
			mode_next = sfa_pkg::MODE_IGNORE;
		end else if (first) begin
			mode_next = sfa_pkg::MODE_FIRST;
		end else if (gt) begin
			mode_next = sfa_pkg::MODE_NEWMAX;
		end else begin
			mode_next = sfa_pkg::MODE_OTHER;
		end
	end

	// Exponential in two multiply steps: integer part times high nibble, then low nibble.
	assign big = d_q >= DW'(sfa_pkg::EXP_CUTOFF);
	assign p1  = sfa_pkg::exp_int(d_q[11:8]) * sfa_pkg::exp_hi(d_q[7:4]);
	assign r1  = p1 + (2*EW)'(32768);
	assign p2  = v1_q * sfa_pkg::exp_lo(d_q[3:0]);
	assign r2  = p2 + (2*EW)'(32768);

	assign add_sum = {1'b0, sum_q} + (SW+1)'(e_q);
	assign sum_add = add_sum[SW] ? '1 : add_sum[SW-1:0];

	assign rnd       = prod_q + PRW'(32768);
	assign sc_sum    = (SW+2)'(rnd[PRW-1:16]) + (SW+2)'(sfa_pkg::ONE_Q16);
	assign sum_scale = (sc_sum[SW+1:SW] != 2'b00) ? '1 : sc_sum[SW-1:0];

	// One quotient bit per step of a restoring divider.
	assign trial      = {rem_q, quo_q[EW-1]};
	assign ge         = trial >= {1'b0, div_q};
	assign trial_diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= {1'b1, {(LOGIT_BITS-1){1'b0}}};
			pos_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			mode_q      <= sfa_pkg::MODE_FIRST;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.load) begin
				mode_q <= mode_next;
				last_q <= last;
				if (!full) begin
					count_q <= count_q + 1'b1;
					if (first) begin
						max_q <= logit;
						pos_q <= '0;
					end else if (gt) begin
						max_q <= logit;
						pos_q <= count_q[PW-1:0];
					end
				end
			end
			if (cmd.emit) begin
				max_q   <= {1'b1, {(LOGIT_BITS-1){1'b0}}};
				pos_q   <= '0;
				count_q <= '0;
				sum_q   <= '0;
			end else if (cmd.acc) begin
				unique case (mode_q)
					sfa_pkg::MODE_FIRST:  sum_q <= SW'(sfa_pkg::ONE_Q16);
					sfa_pkg::MODE_OTHER:  sum_q <= sum_add;
					sfa_pkg::MODE_NEWMAX: sum_q <= sum_q;
					sfa_pkg::MODE_IGNORE: sum_q <= sum_q;
				endcase
			end else if (cmd.scale) begin
				sum_q <= sum_scale;
			end
			if (cmd.div_start) begin
				div_cnt_q <= NW'(sfa_pkg::DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q <= d_next;
		end
		if (cmd.exp1) begin
			v1_q <= big ? '0 : r1[2*EW-2:16];
		end
		if (cmd.exp2) begin
			e_q <= r2[2*EW-2:16];
		end
		if (cmd.acc) begin
			prod_q <= sum_q * e_q;
		end
		if (cmd.div_start) begin
			// Numerator 2^32 + sum/2; its top sixteen bits seed the remainder.
			div_q   <= sum_q;
			rem_q   <= SW'({2'b10, sum_q[SW-1:18]});
			quo_q   <= sum_q[EW:1];
			small_q <= sum_q[SW-1:16] == '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_diff[SW-1:0] : trial[SW-1:0];
			quo_q <= {quo_q[EW-2:0], ge};
		end
		if (cmd.emit) begin
			class_index_q <= 10'(pos_q);
			score_q       <= (small_q || quo_q[EW-1]) ? 16'hFFFF : quo_q[15:0];
		end
	end

	assign sts.mode     = mode_q;
	assign sts.last     = last_q;
	assign sts.div_last = div_cnt_q == '0;
	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign class_index  = class_index_q;
	assign score        = score_q;

endmodule

`default_nettype wire

@@ rtl/sfa_ctrl.sv @@
`default_nettype none

module sfa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire sfa_pkg::sfa_sts_t sts,
	output sfa_pkg::sfa_cmd_t      cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EXP1  = 8'b0000_0010,
		ST_EXP2  = 8'b0000_0100,
		ST_ACC   = 8'b0000_1000,
		ST_SCALE = 8'b0001_0000,
		ST_PREP  = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_EXP1;
				end
			end
			ST_EXP1: begin
				cmd.exp1   = 1'b1;
				state_next = ST_EXP2;
			end
			ST_EXP2: begin
				cmd.exp2   = 1'b1;
				state_next = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (sts.mode == sfa_pkg::MODE_NEWMAX) begin
					state_next = ST_SCALE;
				end else if (sts.last) begin
					state_next = ST_PREP;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_SCALE: begin
				cmd.scale  = 1'b1;
				state_next = sts.last ? ST_PREP : ST_IDLE;
			end
			ST_PREP: begin
				cmd.div_start = 1'b1;
				state_next    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign item_stall = state_q != ST_IDLE;

endmodule

`default_nettype wire

@@ rtl/softmax_argmax_classifier.sv @@
`default_nettype none

// Streaming softmax arg-max over the class logits of one image. Each accepted word
// carries one signed Q8.8 logit and a last flag; the word with last set closes the
// run and yields one result word with the position of the first largest logit and
// its softmax probability as unsigned Q0.16, where a probability of one saturates
// to 65535. The sum of exponentials is kept relative to the running maximum and is
// rescaled whenever a strictly larger logit arrives, so no term exceeds one. Logits
// past MAX_CLASSES in a run are dropped, but their last flag still closes the run.
// A logit occupies the block through accept, two table-and-multiply steps of the
// exponential and accumulate, and through a rescale multiply as well when it is a
// new maximum. The word that closes a run then occupies it while the divider is
// set up, for the 17 one-bit steps of the restoring divider that forms the score,
// and while the output register is loaded, plus any wait for the previous result
// to be taken. The output register lets a new logit be accepted while an earlier
// result is still waiting downstream.
module softmax_argmax_classifier #(
	parameter int MAX_CLASSES = 1024,
	parameter int LOGIT_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic signed [LOGIT_BITS-1:0] logit,
	input  wire logic                         last,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [9:0]                        class_index,
	output logic [15:0]                       score
);

	// The controller sequences each word; the datapath holds all arithmetic and run state.
	sfa_pkg::sfa_cmd_t cmd;
	sfa_pkg::sfa_sts_t sts;

	sfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sfa_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.LOGIT_BITS  (LOGIT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.logit        (logit),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.class_index  (class_index),
		.score        (score)
	);

endmodule

`default_nettype wire

@@ rtl/sfa_chk.sv @@
`default_nettype none

module sfa_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [9:0]  class_index,
	input wire logic [15:0] score
);

	// Once a word is taken, the block is busy with it on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item_stall low right after an accepted word");

	// Each word holds the input off through its exponential and accumulate states before the next can enter.
	a_min_item_time: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_stall) |-> $past(item_stall, 2) && $past(item_stall, 3))
		else $error("input released too early after a word");

	// A new result only appears after the divider has run with the input held off.
	a_result_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall, 1) && $past(item_stall, 17))
		else $error("result appeared without a completed division");

	// A waiting result holds its word.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(class_index) && $stable(score))
		else $error("stalled result changed");

endmodule

bind softmax_argmax_classifier sfa_chk u_sfa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.class_index  (class_index),
	.score        (score)
);

`default_nettype wire

@@ verif/softmax_argmax_classifier_test.sv @@
`timescale 1ns / 100ps

// Streaming softmax arg-max check. Logit words are queued up front, fed by a
// driver that idles at random, and every accepted word is folded into a local
// copy of the online softmax state. The word that closes an image queues the
// predicted winner, and the monitor compares each result word against the
// oldest prediction.
module softmax_argmax_classifier_test;

	localparam int MAX_CLASSES = 1024;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [15:0] value;
		logic        closes;
	} logit_word_t;

	typedef struct packed {
		logic [9:0]  cls;
		logic [15:0] prob;
	} winner_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic signed [15:0] logit = '0;
	logic               last = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [9:0]         class_index;
	logic [15:0]        score;

	softmax_argmax_classifier u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.logit        (logit),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.class_index  (class_index),
		.score        (score)
	);

	always #2 clk = ~clk;

	// Exponential tables in Q16.16: exp(-i), exp(-h/16) and exp(-l/256).
	int unsigned whole_steps [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
		22, 8, 3, 1};
	int unsigned coarse_steps [16] = '{65536, 61565, 57835, 54331, 51039, 47947,
		45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
	int unsigned fine_steps [16] = '{65536, 65280, 65026, 64772, 64520, 64268,
		64018, 63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

	// Running state of the image currently being folded in.
	logic signed [15:0] peak = 16'sh8000;
	int                 peak_pos = 0;
	longint unsigned    exp_total = 0;
	int                 run_len = 0;
	int                 image_words = 0;
	int                 longest_image = 0;

	logit_word_t pending_words [$];
	winner_t     predicted_winners [$];

	bit feeding = 1'b0;
	bit item_taken = 1'b0;
	bit hold_off = 1'b0;
	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int words_sent = 0;
	int words_taken = 0;
	int results_seen = 0;
	int mismatches = 0;

	// exp(-d/256) for a non-negative Q8.8 distance, as Q16.16. Distances of
	// twelve or more whole units fall off the table and give zero.
	function automatic longint unsigned neg_exp(input int unsigned d);
		longint unsigned v;
		if ((d >> 8) >= 12)
			return 0;
		v = whole_steps[d >> 8];
		v = (v * coarse_steps[(d >> 4) & 15] + 32768) >> 16;
		v = (v * fine_steps[d & 15] + 32768) >> 16;
		return v;
	endfunction

	function automatic longint unsigned clip_sum(input longint unsigned s);
		return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
	endfunction

	// Folds one accepted logit into the running state. Returns 1 when the word
	// closes the image, with the winner in w; the run state is then cleared.
	function automatic bit absorb_logit(input logic signed [15:0] x, input logic closes,
			output winner_t w);
		longint unsigned e;
		longint unsigned q;
		w = '0;
		if (run_len < MAX_CLASSES) begin
			if (run_len == 0) begin
				peak = x;
				peak_pos = 0;
				exp_total = 65536;
			end else if (x > peak) begin
				// A strictly larger logit: rescale the old sum to the new maximum.
				e = neg_exp(int'(x) - int'(peak));
				exp_total = clip_sum(((exp_total * e + 32768) >> 16) + 65536);
				peak = x;
				peak_pos = run_len;
			end else begin
				// Ties land here, so the earlier position keeps the win.
				exp_total = clip_sum(exp_total + neg_exp(int'(peak) - int'(x)));
			end
			run_len++;
		end
		image_words++;
		if (!closes)
			return 1'b0;
		q = 65535;
		if (exp_total != 0) begin
			q = ((64'd1 << 32) + (exp_total >> 1)) / exp_total;
			if (q > 65535)
				q = 65535;
		end
		w.cls = peak_pos[9:0];
		w.prob = q[15:0];
		if (image_words > longest_image)
			longest_image = image_words;
		peak = 16'sh8000;
		peak_pos = 0;
		exp_total = 0;
		run_len = 0;
		image_words = 0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch: %s at result %0d, got %0d, want %0d", what, results_seen,
			got, want);
	endtask

	// Pause lengths for both sides: mostly none or short, now and then long.
	// During calm stretches neither side idles at all.
	function automatic int pick_pause(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(12, 48);
	endfunction

	task automatic queue_word(input int v, input bit closes);
		logit_word_t w;
		w.value = v[15:0];
		w.closes = closes;
		pending_words.insert(pending_words.size(), w);
	endtask

	// Random logit of a given flavor: full range, clustered within 2000 of a center,
	// near-ties on a coarse grid, or the extremes and the sign boundary of the
	// field.
	function automatic int draw_logit(input int flavor, input int center);
		int v;
		case (flavor)
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = center + int'($urandom_range(0, 4000)) - 2000;
			2: v = center - 64 * int'($urandom_range(0, 3));
			default: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	// Image sizes lean short so that plenty of images close.
	function automatic int pick_image_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 5);
		if (r < 95)
			return $urandom_range(6, 16);
		return $urandom_range(17, 64);
	endfunction

	task automatic queue_image(input int n, input int flavor);
		int center;
		center = int'($urandom_range(0, 65535)) - 32768;
		for (int k = 0; k < n; k++)
			queue_word(draw_logit(flavor, center), k == n - 1);
	endtask

	// Input side: a word sits on the port until it is taken, then the next one
	// follows, possibly after a gap. Changes land on the falling edge.
	always @(negedge clk) begin : feed_words
		logit_word_t w;
		calm = (words_sent % 600) >= 450;
		if (feeding && (!item_valid || item_taken)) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				item_valid <= 1'b1;
				logit <= w.value;
				last <= w.closes;
				words_sent++;
				send_gap = pick_pause(calm);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Output side stall. The hold-off keeps the result side blocked long enough
	// for the output register and the datapath to fill, so the input stalls too.
	always @(negedge clk) begin
		if (hold_off) begin
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			stall_left = pick_pause(calm);
		end
	end

	// Both handshakes are sampled on the rising edge. A taken logit word goes
	// through the predictor; a taken result word is checked field by field.
	always @(posedge clk) begin : watch_ports
		winner_t w;
		winner_t want;
		item_taken = 1'b0;
		if (arst_n && item_valid && !item_stall) begin
			item_taken = 1'b1;
			words_taken++;
			if (absorb_logit(logit, last, w))
				predicted_winners.insert(predicted_winners.size(), w);
		end
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_winners.size() == 0) begin
				report_mismatch("result word with nothing pending, class_index", class_index, -1);
			end else begin
				want = predicted_winners.pop_front();
				if (class_index !== want.cls)
					report_mismatch("class_index", class_index, want.cls);
				if (score !== want.prob)
					report_mismatch("score", score, want.prob);
			end
			results_seen++;
		end
	end

	// One long receiver hold-off early in the random part.
	initial begin
		while (words_taken < 400)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Generous limit: far above the slowest legal run of every pause at its
	// longest plus the divider time for each image.
	initial begin
		#2_500_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		// Directed images. A single logit at either extreme wins with full score.
		queue_word(-32768, 1'b1);
		queue_word(32767, 1'b1);
		// Full-range distances in both orders: the other term falls off the table.
		queue_word(32767, 1'b0);
		queue_word(-32768, 1'b1);
		queue_word(-32768, 1'b0);
		queue_word(32767, 1'b1);
		// Equal logits keep the first position.
		queue_word(100, 1'b0);
		queue_word(100, 1'b0);
		queue_word(100, 1'b1);
		// A tie with a later maximum keeps the position of that maximum.
		queue_word(5, 1'b0);
		queue_word(7, 1'b0);
		queue_word(7, 1'b1);
		// Distances right below and at the table cutoff, below and above the max.
		queue_word(0, 1'b0);
		queue_word(-3071, 1'b1);
		queue_word(0, 1'b0);
		queue_word(-3072, 1'b1);
		queue_word(-3072, 1'b0);
		queue_word(0, 1'b1);
		// The smallest step up.
		queue_word(0, 1'b0);
		queue_word(1, 1'b1);

		// Random images of mixed flavors.
		while (pending_words.size() < 850)
			queue_image(pick_image_len(), $urandom_range(0, 3));

		// One image longer than MAX_CLASSES. The winner sits at the last counted
		// position, and the words past the limit would beat it if they counted.
		for (int p = 0; p < MAX_CLASSES + 10; p++) begin
			if (p == MAX_CLASSES - 1)
				queue_word(30000, 1'b0);
			else if (p >= MAX_CLASSES)
				queue_word(32767, p == MAX_CLASSES + 9);
			else
				queue_word(int'($urandom_range(0, 40000)) - 20000, 1'b0);
		end

		while (pending_words.size() < 1920)
			queue_image(pick_image_len(), $urandom_range(0, 3));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		feeding = 1'b1;

		while (pending_words.size() != 0 || item_valid)
			@(posedge clk);
		while (predicted_winners.size() != 0)
			@(posedge clk);
		// Room for a stray result word after the last expected one.
		repeat (60) @(posedge clk);

		$display("Fed %0d logit words and checked %0d result words; longest image %0d logits.",
			words_taken, results_seen, longest_image);
		$display("Included a %0d-cycle receiver hold-off and %0d mismatches.",
			HOLD_OFF_CYCLES, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
